FILE: src/gca_pkg.sv
// ----------------------------------------------------------------------------
// gca_pkg
// Shared types and constants for the gravity compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gca_pkg;

    // sine / cosine pair out of a CORDIC lane, Q2.30
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sc_t;

    // pipeline depths of the fixed parts
    localparam int PH_LAT = 5;
    localparam int GR_LAT = 2;

    // arctangent table length
    localparam int TABLE_LEN = 24;

    // degrees Q9.6 to binary angle: q = floor((mag * 2^23 + 22) / 45)
    //   = mag * 186413 + floor((mag * 23 + 22) / 45)
    localparam logic [17:0] HI_MUL   = 18'd186413;
    localparam logic [4:0]  LO_MUL   = 5'd23;
    localparam logic [4:0]  LO_ADD   = 5'd22;
    localparam logic [5:0]  DIV_K    = 6'd45;
    // floor(2^24 / 45); estimate is low by at most one
    localparam logic [18:0] RECIP    = 19'd372827;
    localparam int          RECIP_SH = 24;

    // CORDIC start value, round(K * 2^30)
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: src/gca_if.sv
// ----------------------------------------------------------------------------
// gca_if
// Valid/ready channels for attitude + acceleration beats and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gca_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (
        output valid, roll_deg, pitch_deg, yaw_deg, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, roll_deg, pitch_deg, yaw_deg, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface gca_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;

    modport source (
        output valid, corr_x, corr_y, corr_z,
        input  ready
    );
    modport sink (
        input  valid, corr_x, corr_y, corr_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/gca_phase.sv
// ----------------------------------------------------------------------------
// gca_phase
// Degrees (Q9.6) to 32-bit binary angle, folded into [-90, +90) degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module gca_phase (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] deg,
    output logic signed [31:0]      z,
    output logic                    flip
);

    // stage 1: magnitude and sign
    logic [16:0] mag_reg;
    logic        neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= deg[15] ? (17'd0 - {deg[15], deg}) : {1'b0, deg};
            neg1_reg <= deg[15];
        end
    end

    // stage 2: mag times the integer part of 2^23 / 45, and the remainder term
    logic [34:0] hi_prod;
    logic [31:0] hi2_reg;
    logic [19:0] v2_reg;
    logic        neg2_reg;

    assign hi_prod = 35'(mag_reg) * 35'(gca_pkg::HI_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi2_reg  <= hi_prod[31:0];
            v2_reg   <= 20'(20'(mag_reg) * 20'(gca_pkg::LO_MUL) + 20'(gca_pkg::LO_ADD));
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: reciprocal estimate of v / 45
    logic [38:0] rc_prod;
    logic [14:0] qa3_reg;
    logic [19:0] v3_reg;
    logic [31:0] hi3_reg;
    logic        neg3_reg;

    assign rc_prod = 39'(v2_reg) * 39'(gca_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa3_reg  <= rc_prod[gca_pkg::RECIP_SH +: 15];
            v3_reg   <= v2_reg;
            hi3_reg  <= hi2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // stage 4: one-step correction, sum the two parts
    logic [19:0] rem4;
    logic [14:0] qlo4;
    logic [31:0] q4_reg;
    logic        neg4_reg;

    assign rem4 = v3_reg - 20'(20'(qa3_reg) * 20'(gca_pkg::DIV_K));
    assign qlo4 = (rem4 >= 20'(gca_pkg::DIV_K)) ? qa3_reg + 15'd1 : qa3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q4_reg   <= hi3_reg + 32'(qlo4);
            neg4_reg <= neg3_reg;
        end
    end

    // stage 5: apply sign, fold the back half-circle by a half turn
    logic [31:0] ph5;
    logic        fold5;
    logic [31:0] z_reg;
    logic        flip_reg;

    assign ph5   = neg4_reg ? (32'd0 - q4_reg) : q4_reg;
    assign fold5 = ph5[31] ^ ph5[30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= {ph5[31] ^ fold5, ph5[30:0]};
            flip_reg <= fold5;
        end
    end

    assign z    = signed'(z_reg);
    assign flip = flip_reg;

endmodule

`default_nettype wire

FILE: src/gca_cordic.sv
// ----------------------------------------------------------------------------
// gca_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module gca_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] z_in,
    input  wire logic               flip_in,
    output gca_pkg::sc_t            sc
);

    localparam int N = (STAGES < gca_pkg::TABLE_LEN) ? STAGES : gca_pkg::TABLE_LEN;

    logic signed [31:0] x_reg    [N+1];
    logic signed [31:0] y_reg    [N+1];
    logic signed [31:0] z_reg    [N+1];
    logic               flip_reg [N+1];
    gca_pkg::sc_t       sc_reg;

    // seed stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gca_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
            flip_reg[0] <= flip_in;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] ang;

        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign ang = signed'(gca_pkg::atan_entry(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][31])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg.s <= flip_reg[N] ? -y_reg[N] : y_reg[N];
            sc_reg.c <= flip_reg[N] ? -x_reg[N] : x_reg[N];
        end
    end

    assign sc = sc_reg;

endmodule

`default_nettype wire

FILE: src/gca_grav.sv
// ----------------------------------------------------------------------------
// gca_grav
// Gravity vector from roll/pitch sin-cos, subtract from accel, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module gca_grav (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire gca_pkg::sc_t       roll_sc,
    input  wire gca_pkg::sc_t       pitch_sc,
    input  wire logic signed [15:0] ax,
    input  wire logic signed [15:0] ay,
    input  wire logic signed [15:0] az,
    output logic signed [15:0]      cx,
    output logic signed [15:0]      cy,
    output logic signed [15:0]      cz
);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] d);
        logic signed [15:0] r;
        if (d > 18'sd32767)
            r = 16'sh7FFF;
        else if (d < -18'sd32768)
            r = 16'sh8000;
        else
            r = d[15:0];
        return r;
    endfunction

    // stage 1: products, X rounding
    logic signed [32:0] sp_rnd;
    logic signed [63:0] py_reg;
    logic signed [63:0] pz_reg;
    logic signed [16:0] gxn_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;

    assign sp_rnd = 33'(pitch_sc.s) + 33'sd131072;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg  <= 64'(roll_sc.s) * 64'(pitch_sc.c);
            pz_reg  <= 64'(roll_sc.c) * 64'(pitch_sc.c);
            gxn_reg <= 17'(sp_rnd >>> 18);
            ax_reg  <= ax;
            ay_reg  <= ay;
            az_reg  <= az;
        end
    end

    // stage 2: round Y/Z to Q4.12, subtract, saturate
    logic signed [63:0] py_rnd;
    logic signed [63:0] pz_rnd;
    logic signed [16:0] gy;
    logic signed [16:0] gz;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
    logic signed [15:0] cx_reg;
    logic signed [15:0] cy_reg;
    logic signed [15:0] cz_reg;

    assign py_rnd = py_reg + 64'sh0000_8000_0000_0000;
    assign pz_rnd = pz_reg + 64'sh0000_8000_0000_0000;
    assign gy     = 17'(py_rnd >>> 48);
    assign gz     = 17'(pz_rnd >>> 48);
    // X gravity is -sin(pitch), so its removal is an add
    assign dx     = 18'(ax_reg) + 18'(gxn_reg);
    assign dy     = 18'(ay_reg) - 18'(gy);
    assign dz     = 18'(az_reg) - 18'(gz);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= sat16(dx);
            cy_reg <= sat16(dy);
            cz_reg <= sat16(dz);
        end
    end

    assign cx = cx_reg;
    assign cy = cy_reg;
    assign cz = cz_reg;

endmodule

`default_nettype wire

FILE: src/gravity_compensate_accel_top.sv
// Path: an accepted input beat goes through angle conversion, the CORDIC and
//   gravity removal with saturation, all registered, to its result beat.
// Throughput: one beat per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: rst_n async active low clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// gravity_compensate_accel_top
// Removes one g of gravity from a body-frame accel sample using roll/pitch.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_compensate_accel_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gca_in_if.sink     sample,
    gca_out_if.source  result
);

    localparam int N_ACT    = (CORDIC_STAGES < gca_pkg::TABLE_LEN) ?
                              CORDIC_STAGES : gca_pkg::TABLE_LEN;
    localparam int CORD_LAT = N_ACT + 2;
    localparam int ACC_DLY  = gca_pkg::PH_LAT + CORD_LAT;
    localparam int LAT      = ACC_DLY + gca_pkg::GR_LAT;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic signed [31:0] roll_z;
    logic signed [31:0] pitch_z;
    logic               roll_flip;
    logic               pitch_flip;
    gca_pkg::sc_t       roll_sc;
    gca_pkg::sc_t       pitch_sc;
    logic signed [15:0] ax_dly_reg [ACC_DLY];
    logic signed [15:0] ay_dly_reg [ACC_DLY];
    logic signed [15:0] az_dly_reg [ACC_DLY];

    // global advance: move unless the last stage holds an untaken beat
    assign en           = !vld_reg[LAT-1] || result.ready;
    assign sample.ready = en;
    assign result.valid = vld_reg[LAT-1];

    // valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample.valid};
    end

    // accel delay line, matched to the angle path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_dly_reg[0] <= sample.accel_x;
            ay_dly_reg[0] <= sample.accel_y;
            az_dly_reg[0] <= sample.accel_z;
            for (int k = 1; k < ACC_DLY; k++)
            begin
                ax_dly_reg[k] <= ax_dly_reg[k-1];
                ay_dly_reg[k] <= ay_dly_reg[k-1];
                az_dly_reg[k] <= az_dly_reg[k-1];
            end
        end
    end

    // angle conversion (yaw cancels and is not used)
    gca_phase u_roll_phase (
        .clk  (clk),
        .en   (en),
        .deg  (sample.roll_deg),
        .z    (roll_z),
        .flip (roll_flip)
    );

    gca_phase u_pitch_phase (
        .clk  (clk),
        .en   (en),
        .deg  (sample.pitch_deg),
        .z    (pitch_z),
        .flip (pitch_flip)
    );

    // sine / cosine
    gca_cordic #(.STAGES(CORDIC_STAGES)) u_roll_cordic (
        .clk     (clk),
        .en      (en),
        .z_in    (roll_z),
        .flip_in (roll_flip),
        .sc      (roll_sc)
    );

    gca_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_cordic (
        .clk     (clk),
        .en      (en),
        .z_in    (pitch_z),
        .flip_in (pitch_flip),
        .sc      (pitch_sc)
    );

    // gravity removal and output register
    gca_grav u_grav (
        .clk      (clk),
        .en       (en),
        .roll_sc  (roll_sc),
        .pitch_sc (pitch_sc),
        .ax       (ax_dly_reg[ACC_DLY-1]),
        .ay       (ay_dly_reg[ACC_DLY-1]),
        .az       (az_dly_reg[ACC_DLY-1]),
        .cx       (result.corr_x),
        .cy       (result.corr_y),
        .cz       (result.corr_z)
    );

endmodule

`default_nettype wire
